/* rtl/fast_approx_square_root_macros.svh */
// Assertion helpers shared by the RTL. Both expect clk and rst_n in scope.
`ifndef FAST_APPROX_SQUARE_ROOT_MACROS_SVH
`define FAST_APPROX_SQUARE_ROOT_MACROS_SVH

// Same-cycle implication.
`define FASR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FASR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/fasr_pkg.sv */
`default_nettype none

package fasr_pkg;

  localparam logic [31:0] SEED_MAGIC = 32'h5f3759df;
  localparam logic [31:0] SP_HALF    = 32'h3F000000;
  localparam logic [31:0] SP_ONE     = 32'h3F800000;
  localparam logic [31:0] SP_QNAN    = 32'h7FC00000;
  // 1.5 as significand 1.1b with unbiased exponent 0
  localparam logic [23:0] THREE_HALVES_M = 24'hC00000;

  localparam logic signed [10:0] EXP_MIN = -11'sd126;
  localparam logic signed [10:0] EXP_MAX = 11'sd127;

  localparam int FMUL_DEPTH = 4;
  localparam int UPD_DEPTH  = 7;

  typedef enum logic [1:0] {
    CLS_ZERO,
    CLS_NORM,
    CLS_INF,
    CLS_NAN
  } fasr_cls_t;

  // Value = m * 2^(e-23), m normalized with bit 23 set for CLS_NORM.
  typedef struct packed {
    logic             s;
    fasr_cls_t        cls;
    logic signed [10:0] e;
    logic [23:0]      m;
  } fasr_sp_t;

  // Aligned single-precision significand ready for rounding and packing.
  typedef struct packed {
    logic [7:0]  base;
    logic [23:0] keep;
    logic        g;
    logic        stk;
  } fasr_rnd_t;

  // Operands that travel with each request.
  typedef struct packed {
    logic [31:0] v;
    logic [31:0] x;
    logic [31:0] y;
    logic        one;
  } fasr_side_t;

  function automatic logic [4:0] lead_pos24(input logic [23:0] m);
    logic [4:0] p;
    p = 5'd0;
    for (int i = 0; i < 24; i++) begin
      if (m[i]) p = 5'(i);
    end
    return p;
  endfunction

  function automatic fasr_sp_t sp_unpack(input logic [31:0] b);
    fasr_sp_t   u;
    logic [4:0] k;
    u.s   = b[31];
    u.cls = CLS_NORM;
    u.e   = 11'sd0;
    u.m   = {1'b1, b[22:0]};
    k     = lead_pos24({1'b0, b[22:0]});
    if (b[30:23] == 8'hFF) begin
      u.cls = (b[22:0] != 23'd0) ? CLS_NAN : CLS_INF;
    end else if (b[30:23] == 8'd0) begin
      if (b[22:0] == 23'd0) begin
        u.cls = CLS_ZERO;
        u.m   = 24'd0;
      end else begin
        u.m = {1'b0, b[22:0]} << (5'd23 - k);
        u.e = $signed({6'd0, k}) - 11'sd149;
      end
    end else begin
      u.e = $signed({3'd0, b[30:23]}) - 11'sd127;
    end
    return u;
  endfunction

  // Denormalize below the normal range and split into keep, guard, sticky.
  function automatic fasr_rnd_t sp_align(input logic signed [10:0] e,
                                         input logic [63:0] m, input logic st);
    logic signed [10:0] sh;
    logic signed [10:0] bs;
    logic [63:0]        shv;
    logic [63:0]        mask;
    logic               lost;
    fasr_rnd_t          r;
    mask = 64'd0;
    if (e >= EXP_MIN) begin
      sh = 11'sd0;
      bs = e + 11'sd126;
    end else begin
      sh = EXP_MIN - e;
      bs = 11'sd0;
    end
    if (sh > 11'sd63) begin
      shv  = 64'd0;
      lost = |m;
    end else begin
      shv  = m >> sh[5:0];
      mask = (64'd1 << sh[5:0]) - 64'd1;
      lost = |(m & mask);
    end
    r.base = bs[7:0];
    r.keep = shv[63:40];
    r.g    = shv[39];
    r.stk  = (|shv[38:0]) | lost | st;
    return r;
  endfunction

  // Round to nearest even; a carry out of the significand bumps the exponent.
  function automatic logic [30:0] sp_pack(input fasr_rnd_t r);
    logic inc;
    inc = r.g & (r.stk | r.keep[0]);
    return {r.base, 23'd0} + {7'd0, r.keep} + {30'd0, inc};
  endfunction

endpackage

`default_nettype wire

/* rtl/fasr_fmul.sv */
`default_nettype none
`include "fast_approx_square_root_macros.svh"

module fasr_fmul (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [31:0]          in_a,
  input  logic [31:0]          in_b,
  input  fasr_pkg::fasr_side_t in_side,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [31:0]          out_prod,
  output fasr_pkg::fasr_side_t out_side
);
  import fasr_pkg::*;

  logic [FMUL_DEPTH-1:0] vld_r;
  logic [FMUL_DEPTH:0]   adv;

  fasr_sp_t   a1_r, b1_r;
  fasr_side_t sd1_r, sd2_r, sd3_r, sd4_r;

  logic               s2_r, s2_nxt;
  fasr_cls_t          c2_r, c2_nxt;
  logic signed [10:0] e2_r;
  logic [47:0]        p2_r;

  logic               s3_r;
  fasr_cls_t          c3_r;
  fasr_rnd_t          r3_r, r3_nxt;
  logic               ovf3_r, ovf3_nxt;
  logic signed [10:0] e3;
  logic [47:0]        n3;

  logic [31:0] prod4_r, prod4_nxt;

  // Stage k moves when it is empty or its successor moves.
  always_comb begin
    adv[FMUL_DEPTH] = out_ready;
    for (int k = FMUL_DEPTH - 1; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  assign in_ready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) vld_r[0] <= in_valid;
      for (int k = 1; k < FMUL_DEPTH; k++) begin
        if (adv[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // Classify the product.
  always_comb begin
    s2_nxt = a1_r.s ^ b1_r.s;
    if (a1_r.cls == CLS_NAN || b1_r.cls == CLS_NAN) begin
      c2_nxt = CLS_NAN;
    end else if ((a1_r.cls == CLS_INF && b1_r.cls == CLS_ZERO) ||
                 (a1_r.cls == CLS_ZERO && b1_r.cls == CLS_INF)) begin
      c2_nxt = CLS_NAN;
    end else if (a1_r.cls == CLS_INF || b1_r.cls == CLS_INF) begin
      c2_nxt = CLS_INF;
    end else if (a1_r.cls == CLS_ZERO || b1_r.cls == CLS_ZERO) begin
      c2_nxt = CLS_ZERO;
    end else begin
      c2_nxt = CLS_NORM;
    end
  end

  // Normalize by one position and align for rounding.
  always_comb begin
    if (p2_r[47]) begin
      n3 = p2_r;
      e3 = e2_r + 11'sd1;
    end else begin
      n3 = {p2_r[46:0], 1'b0};
      e3 = e2_r;
    end
    r3_nxt   = sp_align(e3, {n3, 16'd0}, 1'b0);
    ovf3_nxt = (e3 > EXP_MAX);
  end

  always_comb begin
    case (c3_r)
      CLS_NAN:  prod4_nxt = SP_QNAN;
      CLS_INF:  prod4_nxt = {s3_r, 8'hFF, 23'd0};
      CLS_ZERO: prod4_nxt = {s3_r, 31'd0};
      CLS_NORM: prod4_nxt = ovf3_r ? {s3_r, 8'hFF, 23'd0} : {s3_r, sp_pack(r3_r)};
      default:  prod4_nxt = SP_QNAN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      a1_r  <= sp_unpack(in_a);
      b1_r  <= sp_unpack(in_b);
      sd1_r <= in_side;
    end
    if (adv[1]) begin
      s2_r  <= s2_nxt;
      c2_r  <= c2_nxt;
      e2_r  <= a1_r.e + b1_r.e;
      p2_r  <= a1_r.m * b1_r.m;
      sd2_r <= sd1_r;
    end
    if (adv[2]) begin
      s3_r   <= s2_r;
      c3_r   <= c2_r;
      r3_r   <= r3_nxt;
      ovf3_r <= ovf3_nxt;
      sd3_r  <= sd2_r;
    end
    if (adv[3]) begin
      prod4_r <= prod4_nxt;
      sd4_r   <= sd3_r;
    end
  end

  assign out_valid = vld_r[FMUL_DEPTH-1];
  assign out_prod  = prod4_r;
  assign out_side  = sd4_r;

  `FASR_ASSERT_NEXT(a_fmul_load, in_valid && in_ready, vld_r[0], "fmul: request not captured")
  `FASR_ASSERT_NEXT(a_fmul_hold, vld_r[1] && !adv[1], vld_r[1] && $stable(p2_r), "fmul: stalled product lost")
  `FASR_ASSERT_SAME(a_fmul_nan, out_valid && out_prod[30:23] == 8'hFF && out_prod[22:0] != 23'd0, out_prod == SP_QNAN, "fmul: NaN not canonical")

endmodule

`default_nettype wire

/* rtl/fasr_update.sv */
`default_nettype none

module fasr_update (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [31:0]          in_p,
  input  fasr_pkg::fasr_side_t in_side,
  output logic                 out_valid,
  input  logic                 out_ready,
  output fasr_pkg::fasr_side_t out_side
);
  import fasr_pkg::*;

  logic [UPD_DEPTH-1:0] vld_r;
  logic [UPD_DEPTH:0]   adv;

  fasr_side_t sd1_r, sd2_r, sd3_r, sd4_r, sd5_r, sd6_r, sd7_r;

  // Stage 1: order the operands of 1.5 - p
  fasr_sp_t           pu, y1_r;
  logic [23:0]        bm1_r, sm1_r, bm1_nxt, sm1_nxt;
  logic signed [10:0] be1_r, be1_nxt, diff;
  logic [7:0]         df1_r, df1_nxt;
  logic               sub1_r, bs1_r, bs1_nxt, ss1_nxt;
  fasr_cls_t          dc1_r, dc1_nxt;
  logic               dis1_r;

  // Stage 2: aligned sum
  logic [81:0]        sum2_r, sum2_nxt, xw, shv, mask2;
  logic               lost2;
  logic signed [10:0] be2_r;
  logic               bs2_r, dis2_r;
  fasr_cls_t          dc2_r;
  fasr_sp_t           y2_r;

  // Stage 3: d rounded to double
  logic [4:0]         lp3;
  logic [4:0]         lz3;
  logic [81:0]        nm3;
  logic [53:0]        m54_3;
  logic               inc3;
  logic signed [10:0] e3_tmp;
  logic               ds3_r, ds3_nxt;
  fasr_cls_t          dc3_r, dc3_nxt;
  logic signed [10:0] de3_r, de3_nxt;
  logic [52:0]        dm3_r, dm3_nxt;
  fasr_sp_t           y3_r;

  // Stage 4: partial products of y * d
  logic [50:0]        ph4_r;
  logic [49:0]        pl4_r;
  logic               s4_r;
  fasr_cls_t          c4_r, c4_nxt;
  logic signed [10:0] e4_r;

  // Stage 5: product rounded to double
  logic [76:0]        q5;
  logic [76:0]        n5;
  logic signed [10:0] e5_tmp;
  logic [53:0]        m54_5;
  logic               inc5;
  logic               s5_r;
  fasr_cls_t          c5_r;
  logic signed [10:0] e5_r, e5_nxt;
  logic [52:0]        m5_r, m5_nxt;

  // Stage 6: align to single
  logic               s6_r;
  fasr_cls_t          c6_r;
  fasr_rnd_t          r6_r;
  logic               ovf6_r;

  // Stage 7: packed y
  logic [31:0]        y7_nxt;
  fasr_side_t         sd7_nxt;

  always_comb begin
    adv[UPD_DEPTH] = out_ready;
    for (int k = UPD_DEPTH - 1; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  assign in_ready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) vld_r[0] <= in_valid;
      for (int k = 1; k < UPD_DEPTH; k++) begin
        if (adv[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // Put the larger magnitude first; a zero p leaves 1.5 alone.
  always_comb begin
    pu = sp_unpack(in_p);
    if (pu.cls == CLS_NAN) dc1_nxt = CLS_NAN;
    else if (pu.cls == CLS_INF) dc1_nxt = CLS_INF;
    else dc1_nxt = CLS_NORM;
    if ((11'sd0 > pu.e) || (pu.e == 11'sd0 && THREE_HALVES_M >= pu.m)) begin
      bm1_nxt = THREE_HALVES_M;
      sm1_nxt = pu.m;
      be1_nxt = 11'sd0;
      bs1_nxt = 1'b0;
      ss1_nxt = !pu.s;
      diff    = 11'sd0 - pu.e;
    end else begin
      bm1_nxt = pu.m;
      sm1_nxt = THREE_HALVES_M;
      be1_nxt = pu.e;
      bs1_nxt = !pu.s;
      ss1_nxt = 1'b0;
      diff    = pu.e;
    end
    df1_nxt = (diff > 11'sd255) ? 8'd255 : diff[7:0];
  end

  // Shift the smaller operand with sticky folded into the bottom bit.
  always_comb begin
    xw    = {1'b0, sm1_r, 57'd0};
    mask2 = '0;
    if (df1_r > 8'd81) begin
      shv   = '0;
      lost2 = |sm1_r;
    end else begin
      shv   = xw >> df1_r;
      mask2 = (82'd1 << df1_r) - 82'd1;
      lost2 = |(xw & mask2);
    end
    if (sub1_r) sum2_nxt = {1'b0, bm1_r, 57'd0} - (shv | {81'd0, lost2});
    else        sum2_nxt = {1'b0, bm1_r, 57'd0} + (shv | {81'd0, lost2});
  end

  // Leading one sits within the top 26 bits of any nonzero sum.
  always_comb begin
    lp3 = 5'd0;
    for (int i = 0; i < 26; i++) begin
      if (sum2_r[56+i]) lp3 = 5'(i);
    end
    lz3    = 5'd25 - lp3;
    nm3    = sum2_r << lz3;
    inc3   = nm3[28] & ((|nm3[27:0]) | nm3[29]);
    m54_3  = {1'b0, nm3[81:29]} + {53'd0, inc3};
    e3_tmp = be2_r + 11'sd1 - $signed({6'd0, lz3});
    ds3_nxt = bs2_r;
    dc3_nxt = CLS_NORM;
    if (m54_3[53]) begin
      dm3_nxt = m54_3[53:1];
      de3_nxt = e3_tmp + 11'sd1;
    end else begin
      dm3_nxt = m54_3[52:0];
      de3_nxt = e3_tmp;
    end
    if (dc2_r == CLS_NAN) begin
      dc3_nxt = CLS_NAN;
    end else if (dc2_r == CLS_INF) begin
      dc3_nxt = CLS_INF;
      ds3_nxt = dis2_r;
    end else if (sum2_r == 82'd0) begin
      dc3_nxt = CLS_ZERO;
      ds3_nxt = 1'b0;
    end
  end

  always_comb begin
    if (y3_r.cls == CLS_NAN || dc3_r == CLS_NAN) begin
      c4_nxt = CLS_NAN;
    end else if ((y3_r.cls == CLS_INF && dc3_r == CLS_ZERO) ||
                 (y3_r.cls == CLS_ZERO && dc3_r == CLS_INF)) begin
      c4_nxt = CLS_NAN;
    end else if (y3_r.cls == CLS_INF || dc3_r == CLS_INF) begin
      c4_nxt = CLS_INF;
    end else if (y3_r.cls == CLS_ZERO || dc3_r == CLS_ZERO) begin
      c4_nxt = CLS_ZERO;
    end else begin
      c4_nxt = CLS_NORM;
    end
  end

  // Recombine, normalize and round to 53 bits first.
  always_comb begin
    q5 = ({26'd0, ph4_r} << 26) + {27'd0, pl4_r};
    if (q5[76]) begin
      n5     = q5;
      e5_tmp = e4_r + 11'sd1;
    end else begin
      n5     = {q5[75:0], 1'b0};
      e5_tmp = e4_r;
    end
    inc5  = n5[23] & ((|n5[22:0]) | n5[24]);
    m54_5 = {1'b0, n5[76:24]} + {53'd0, inc5};
    if (m54_5[53]) begin
      m5_nxt = m54_5[53:1];
      e5_nxt = e5_tmp + 11'sd1;
    end else begin
      m5_nxt = m54_5[52:0];
      e5_nxt = e5_tmp;
    end
  end

  always_comb begin
    case (c6_r)
      CLS_NAN:  y7_nxt = SP_QNAN;
      CLS_INF:  y7_nxt = {s6_r, 8'hFF, 23'd0};
      CLS_ZERO: y7_nxt = {s6_r, 31'd0};
      CLS_NORM: y7_nxt = ovf6_r ? {s6_r, 8'hFF, 23'd0} : {s6_r, sp_pack(r6_r)};
      default:  y7_nxt = SP_QNAN;
    endcase
    sd7_nxt   = sd6_r;
    sd7_nxt.y = y7_nxt;
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      bm1_r  <= bm1_nxt;
      sm1_r  <= sm1_nxt;
      be1_r  <= be1_nxt;
      df1_r  <= df1_nxt;
      sub1_r <= bs1_nxt ^ ss1_nxt;
      bs1_r  <= bs1_nxt;
      dc1_r  <= dc1_nxt;
      dis1_r <= !pu.s;
      y1_r   <= sp_unpack(in_side.y);
      sd1_r  <= in_side;
    end
    if (adv[1]) begin
      sum2_r <= sum2_nxt;
      be2_r  <= be1_r;
      bs2_r  <= bs1_r;
      dis2_r <= dis1_r;
      dc2_r  <= dc1_r;
      y2_r   <= y1_r;
      sd2_r  <= sd1_r;
    end
    if (adv[2]) begin
      ds3_r <= ds3_nxt;
      dc3_r <= dc3_nxt;
      de3_r <= de3_nxt;
      dm3_r <= dm3_nxt;
      y3_r  <= y2_r;
      sd3_r <= sd2_r;
    end
    if (adv[3]) begin
      ph4_r <= 51'(y3_r.m) * 51'(dm3_r[52:26]);
      pl4_r <= 50'(y3_r.m) * 50'(dm3_r[25:0]);
      s4_r  <= y3_r.s ^ ds3_r;
      c4_r  <= c4_nxt;
      e4_r  <= y3_r.e + de3_r;
      sd4_r <= sd3_r;
    end
    if (adv[4]) begin
      s5_r  <= s4_r;
      c5_r  <= c4_r;
      e5_r  <= e5_nxt;
      m5_r  <= m5_nxt;
      sd5_r <= sd4_r;
    end
    if (adv[5]) begin
      s6_r   <= s5_r;
      c6_r   <= c5_r;
      r6_r   <= sp_align(e5_r, {m5_r, 11'd0}, 1'b0);
      ovf6_r <= (e5_r > EXP_MAX);
      sd6_r  <= sd5_r;
    end
    if (adv[6]) begin
      sd7_r <= sd7_nxt;
    end
  end

  assign out_valid = vld_r[UPD_DEPTH-1];
  assign out_side  = sd7_r;

endmodule

`default_nettype wire

/* rtl/fasr_newton.sv */
`default_nettype none

module fasr_newton (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  fasr_pkg::fasr_side_t in_side,
  output logic                 out_valid,
  input  logic                 out_ready,
  output fasr_pkg::fasr_side_t out_side
);
  import fasr_pkg::*;

  logic        xy_valid, xy_ready;
  logic [31:0] xy_prod;
  fasr_side_t  xy_side;

  logic        p_valid, p_ready;
  logic [31:0] p_prod;
  fasr_side_t  p_side;

  // x * y
  fasr_fmul u_mul_xy (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_a      (in_side.x),
    .in_b      (in_side.y),
    .in_side   (in_side),
    .out_valid (xy_valid),
    .out_ready (xy_ready),
    .out_prod  (xy_prod),
    .out_side  (xy_side)
  );

  // (x * y) * y
  fasr_fmul u_mul_py (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (xy_valid),
    .in_ready  (xy_ready),
    .in_a      (xy_prod),
    .in_b      (xy_side.y),
    .in_side   (xy_side),
    .out_valid (p_valid),
    .out_ready (p_ready),
    .out_prod  (p_prod),
    .out_side  (p_side)
  );

  // y * (1.5 - p)
  fasr_update u_update (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (p_valid),
    .in_ready  (p_ready),
    .in_p      (p_prod),
    .in_side   (p_side),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_side  (out_side)
  );

endmodule

`default_nettype wire

/* rtl/fast_approx_square_root.sv */
// Approximate single-precision square root, streamed over valid/ready.
// Each request carries the raw bits of an IEEE 754 float; the response is
// the raw bits of v * y, where y starts from the magic-constant inverse
// square root seed and is refined by two Newton steps. An input of exactly
// 1.0 is returned unchanged, and every NaN response is the canonical quiet
// NaN 0x7FC00000. Rounding is to nearest even with gradual underflow; the
// Newton update rounds y * (1.5 - p) first to double and then to single.
// The unit is fully pipelined and takes one request per cycle unless
// out_ready stalls it. A request passes the halving multiply, two Newton
// steps (each two 4-stage multiplies and a 7-stage subtract/update) and
// the final multiply. Every stage keeps its own valid bit and moves
// whenever it is empty or its successor moves, so bubbles are squeezed out
// under backpressure and the final stage doubles as the output register.
`default_nettype none
`include "fast_approx_square_root_macros.svh"

module fast_approx_square_root (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_value_bits,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_root_bits
);
  import fasr_pkg::*;

  fasr_side_t  side0;
  logic [31:0] half_bits;

  logic        hx_valid, hx_ready;
  logic [31:0] hx_prod;
  fasr_side_t  hx_side, nt0_in;

  logic        n0_valid, n0_ready;
  fasr_side_t  n0_side;

  logic        n1_valid, n1_ready;
  fasr_side_t  n1_side;

  logic [31:0] fin_prod;
  fasr_side_t  fin_side;

  // Seed: magic constant minus the input shifted right with the sign copied in.
  assign half_bits = {in_value_bits[31], in_value_bits[31:1]};

  always_comb begin
    side0.v   = in_value_bits;
    side0.x   = 32'd0;
    side0.y   = SEED_MAGIC - half_bits;
    side0.one = (in_value_bits == SP_ONE);
  end

  // x = v * 0.5, rounded once
  fasr_fmul u_half (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_a      (in_value_bits),
    .in_b      (SP_HALF),
    .in_side   (side0),
    .out_valid (hx_valid),
    .out_ready (hx_ready),
    .out_prod  (hx_prod),
    .out_side  (hx_side)
  );

  // Drop the halved value into the sideband.
  always_comb begin
    nt0_in   = hx_side;
    nt0_in.x = hx_prod;
  end

  fasr_newton u_newton0 (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (hx_valid),
    .in_ready  (hx_ready),
    .in_side   (nt0_in),
    .out_valid (n0_valid),
    .out_ready (n0_ready),
    .out_side  (n0_side)
  );

  fasr_newton u_newton1 (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (n0_valid),
    .in_ready  (n0_ready),
    .in_side   (n0_side),
    .out_valid (n1_valid),
    .out_ready (n1_ready),
    .out_side  (n1_side)
  );

  // root = v * y
  fasr_fmul u_final (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (n1_valid),
    .in_ready  (n1_ready),
    .in_a      (n1_side.v),
    .in_b      (n1_side.y),
    .in_side   (n1_side),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_prod  (fin_prod),
    .out_side  (fin_side)
  );

  // Pass an exact 1.0 through untouched.
  assign out_root_bits = fin_side.one ? fin_side.v : fin_prod;

  `FASR_ASSERT_SAME(a_root_nan, out_valid && out_root_bits[30:23] == 8'hFF && out_root_bits[22:0] != 23'd0, out_root_bits == SP_QNAN, "root: NaN not canonical")

endmodule

`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] in_value_bits;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_root_bits;

  localparam logic [31:0] MAGIC_SEED = 32'h5f3759df;
  localparam logic [31:0] ONE_BITS   = 32'h3F800000;
  localparam logic [31:0] QNAN_BITS  = 32'h7FC00000;
  localparam logic [31:0] POS_INF    = 32'h7F800000;
  localparam int          RANDOM_REQS = 1830;
  localparam int          STALL_LIMIT = 3000;
  localparam int          DRAIN_CYCLES = 60;

  // Widen single-precision bits to a real, exactly.
  function automatic real sp_to_real(input logic [31:0] b);
    logic [63:0] d;
    logic [22:0] frac;
    int          ex;
    frac = b[22:0];
    d = {b[31], 63'd0};
    if (b[30:23] == 8'hFF) begin
      d[62:52] = 11'h7FF;
      d[51:29] = frac;
    end else if (b[30:23] != 8'd0) begin
      d[62:52] = 11'(int'(b[30:23]) - 127 + 1023);
      d[51:29] = frac;
    end else if (frac != 23'd0) begin
      // subnormal: normalize the fraction into the double significand
      ex = -126;
      while (!frac[22]) begin
        frac = frac << 1;
        ex--;
      end
      frac = frac << 1;
      ex--;
      d[62:52] = 11'(ex + 1023);
      d[51:29] = frac;
    end
    return $bitstoreal(d);
  endfunction

  // Round a real to single precision, nearest even, with gradual underflow.
  function automatic logic [31:0] real_to_sp(input real r);
    logic [63:0] d;
    logic [63:0] sig;
    logic [23:0] keep;
    logic        grd;
    logic        sticky;
    logic [31:0] mag;
    int          ex;
    int          sh;
    int          base;
    d = $realtobits(r);
    if (d[62:52] == 11'h7FF)
      return (d[51:0] != 52'd0) ? QNAN_BITS : {d[63], POS_INF[30:0]};
    // double subnormals are far below the single range
    if (d[62:52] == 11'd0)
      return {d[63], 31'd0};
    ex = int'(d[62:52]) - 1023;
    if (ex > 127)
      return {d[63], POS_INF[30:0]};
    sig = {11'd0, 1'b1, d[51:0]};
    if (ex >= -126) begin
      sh = 29;
      base = ex + 126;
    end else begin
      sh = 29 + (-126 - ex);
      base = 0;
    end
    if (sh > 60) begin
      keep = 24'd0;
      grd = 1'b0;
      sticky = |sig;
    end else begin
      keep = 24'(sig >> sh);
      grd = sig[sh-1];
      sticky = |(sig & ((64'd1 << (sh - 1)) - 64'd1));
    end
    mag = {1'b0, 8'(base), 23'd0} + {8'd0, keep} + {31'd0, grd & (sticky | keep[0])};
    if (mag >= POS_INF)
      mag = POS_INF;
    return {d[63], mag[30:0]};
  endfunction

  // One refinement of the inverse root estimate: y * (1.5 - x*y*y).
  function automatic logic [31:0] refine_inv_root(input logic [31:0] xb, input logic [31:0] yb);
    logic [31:0] pb;
    real         y;
    real         diff;
    y = sp_to_real(yb);
    pb = real_to_sp(sp_to_real(xb) * y);
    pb = real_to_sp(sp_to_real(pb) * y);
    diff = 1.5 - sp_to_real(pb);
    return real_to_sp(y * diff);
  endfunction

  function automatic logic [31:0] predict_root(input logic [31:0] vb);
    logic [31:0] xb;
    logic [31:0] yb;
    logic [31:0] rb;
    real         v;
    v = sp_to_real(vb);
    if (v == 1.0)
      return vb;
    xb = real_to_sp(v * 0.5);
    yb = MAGIC_SEED - {vb[31], vb[31:1]};
    yb = refine_inv_root(xb, yb);
    yb = refine_inv_root(xb, yb);
    rb = real_to_sp(v * sp_to_real(yb));
    if (rb[30:23] == 8'hFF && rb[22:0] != 23'd0)
      rb = QNAN_BITS;
    return rb;
  endfunction

  // Holds expected roots in request order and compares responses against them.
  class root_scoreboard;
    logic [31:0] pending_roots[$];
    logic [31:0] pending_inputs[$];
    int          mismatches;

    function void note_request(logic [31:0] vb);
      pending_inputs.push_back(vb);
      pending_roots.push_back(predict_root(vb));
    endfunction

    function void check_root(logic [31:0] got);
      logic [31:0] want;
      logic [31:0] src;
      if (pending_roots.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("tb_top: unexpected response root_bits=%h", got);
        return;
      end
      want = pending_roots.pop_front();
      src = pending_inputs.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("tb_top: value_bits=%h root_bits expected %h, got %h", src, want, got);
      end
    endfunction

    function int outstanding();
      return pending_roots.size();
    endfunction
  endclass

  root_scoreboard sb;
  bit             quiet_phase;
  int             idle_cycles;

  fast_approx_square_root DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_value_bits(in_value_bits),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_root_bits(out_root_bits)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Note every accepted request and check every accepted response.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      sb.note_request(in_value_bits);
    if (rst_n && out_valid && out_ready)
      sb.check_root(out_root_bits);
  end

  // Receiver: stall in random bursts, never in the quiet phase.
  always @(posedge clk) begin : receiver
    int stall_left;
    if (!rst_n) begin
      stall_left = 0;
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= (stall_left == 0);
    end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 7);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog: end the run if no handshake happens for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // Hold the request until accepted, then maybe drop valid for a burst.
  task automatic send_request(input logic [31:0] vb);
    int gap;
    in_valid <= 1'b1;
    in_value_bits <= vb;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    if (!quiet_phase && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0)
      @(posedge clk);
  endtask

  // Random operand, weighted toward classes that exercise distinct paths.
  function automatic logic [31:0] pick_operand();
    logic [31:0] b;
    b = $urandom;
    case ($urandom_range(0, 9))
      0, 1, 2: b[31] = 1'b0;                                 // positive normals mostly
      3:       b[30:23] = 8'd0;                              // subnormal or zero
      4:       b[30:23] = 8'hFF;                             // infinity or NaN
      5:       b[30:23] = 8'(126 + $urandom_range(0, 2));    // near one
      6:       b = {$urandom_range(0, 1) == 1, ONE_BITS[30:0]};
      default: ;
    endcase
    return b;
  endfunction

  initial begin
    logic [31:0] directed[$];
    sb = new();
    quiet_phase = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_value_bits = 32'd0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Extremes, the pass-through of one, zeros, infinities, NaNs, subnormals,
    // and negatives whose seed subtraction wraps.
    directed = '{32'h00000000, 32'h80000000, ONE_BITS, 32'hBF800000, POS_INF,
                 32'hFF800000, QNAN_BITS, 32'h7F800001, 32'hFFFFFFFF, 32'h00000001,
                 32'h007FFFFF, 32'h00800000, 32'h7F7FFFFF, 32'h40800000, 32'h3E800000,
                 32'h80000001, 32'hC0800000, MAGIC_SEED, 32'h00000002, 32'hBE3759DF,
                 32'h3F800001, 32'h3F7FFFFF, 32'hAAAAAAAA, 32'h55555555};
    foreach (directed[i])
      send_request(directed[i]);

    // Let every directed response come back before the random stream.
    wait_drained();

    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n == RANDOM_REQS - 200)
        quiet_phase = 1'b1;
      send_request(pick_operand());
    end
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0 && sb.outstanding() == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

endmodule
